### src/htlp_pkg.sv
// Shared types and codes of the linear-probing hash table.
package htlp_pkg;

  localparam int KEY_W   = 31;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 2;
  localparam int REM_W   = 12;
  localparam int PROD_W  = 2 * KEY_W + 1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [REM_W-1:0]  rem_t;

endpackage

### src/htlp_if.sv
// Valid/ready channel interfaces for the command and result transactions.
interface htlp_in_if;
  import htlp_pkg::*;
  logic valid;
  logic ready;
  logic command;
  key_t key;
  modport source(output valid, output command, output key, input ready);
  modport sink(input valid, input command, input key, output ready);
endinterface

interface htlp_out_if;
  import htlp_pkg::*;
  logic      valid;
  logic      ready;
  status_t   status;
  slot_idx_t slot_index;
  modport source(output valid, output status, output slot_index, input ready);
  modport sink(input valid, input status, input slot_index, output ready);
endinterface

### src/htlp_front.sv
// Front end: accepts a command transaction and computes its home slot.
module htlp_front #(
  parameter int TABLE_SIZE   = 16,
  parameter int HASH_MODULUS = 7,
  parameter int AW           = 4,
  parameter int QW           = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  htlp_in_if.sink       in_chan,
  input  logic          clearing,
  input  logic          q_full,
  output logic          q_push,
  output logic [QW-1:0] q_data
);
  import htlp_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MULA = 3'd1;
  localparam logic [2:0] F_SCLA = 3'd2;
  localparam logic [2:0] F_SUBA = 3'd3;
  localparam logic [2:0] F_MULB = 3'd4;
  localparam logic [2:0] F_SCLB = 3'd5;
  localparam logic [2:0] F_SUBB = 3'd6;
  localparam logic [2:0] F_PUSH = 3'd7;

  // Reciprocals are rounded up so that the shifted product is the exact quotient.
  localparam int          MOD_SH    = KEY_W + $clog2(HASH_MODULUS);
  localparam int          TAB_SH    = REM_W + $clog2(TABLE_SIZE);
  localparam logic [63:0] MOD_RECIP = ((64'd1 << MOD_SH) + 64'(HASH_MODULUS) - 64'd1) /
                                      64'(HASH_MODULUS);
  localparam logic [63:0] TAB_RECIP = ((64'd1 << TAB_SH) + 64'(TABLE_SIZE) - 64'd1) /
                                      64'(TABLE_SIZE);
  localparam key_t        MOD_K     = KEY_W'(HASH_MODULUS);
  localparam key_t        TAB_K     = KEY_W'(TABLE_SIZE);

  logic [2:0]        state_r, state_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  key_t              qm_r, qm_nxt;
  rem_t              rem_r, rem_nxt;
  logic              cmd_r;
  key_t              key_r;
  logic              accept;

  assign in_chan.ready = (state_r == F_IDLE) && !clearing;
  assign accept        = in_chan.valid && in_chan.ready;
  assign q_push        = (state_r == F_PUSH) && !q_full;
  assign q_data        = {cmd_r, key_r, rem_r[AW-1:0]};

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    qm_nxt    = qm_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_MULA;
        end
      end
      F_MULA: begin
        prod_nxt  = PROD_W'(key_r) * PROD_W'(MOD_RECIP);
        state_nxt = F_SCLA;
      end
      F_SCLA: begin
        qm_nxt    = KEY_W'(prod_r >> MOD_SH) * MOD_K;
        state_nxt = F_SUBA;
      end
      F_SUBA: begin
        rem_nxt   = REM_W'(key_r - qm_r);
        state_nxt = F_MULB;
      end
      F_MULB: begin
        prod_nxt  = PROD_W'(rem_r) * PROD_W'(TAB_RECIP);
        state_nxt = F_SCLB;
      end
      F_SCLB: begin
        qm_nxt    = KEY_W'(prod_r >> TAB_SH) * TAB_K;
        state_nxt = F_SUBB;
      end
      F_SUBB: begin
        rem_nxt   = rem_r - qm_r[REM_W-1:0];
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    qm_r   <= qm_nxt;
    rem_r  <= rem_nxt;
    if (accept) begin
      cmd_r <= in_chan.command;
      key_r <= in_chan.key;
    end
  end

endmodule

### src/htlp_queue.sv
// Two-entry queue between the hashing front end and the probing back end.
module htlp_queue #(
  parameter int QW = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [QW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [QW-1:0] pop_data,
  output logic          not_empty
);

  logic [QW-1:0] entry_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### src/htlp_back.sv
// Back end: slot store, clearing pass, linear probe sequencer and result register.
module htlp_back #(
  parameter int TABLE_SIZE = 16,
  parameter int AW         = 4,
  parameter int QW         = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [QW-1:0] q_data,
  output logic          q_pop,
  output logic          clearing,
  htlp_out_if.source    out_chan
);
  import htlp_pkg::*;

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_PROBE = 2'd2;
  localparam logic [1:0] B_DONE  = 2'd3;

  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);

  key_t slot_keys_r [TABLE_SIZE];
  key_t rdata_r;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] s_r, s_nxt, s_inc;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          cmd_r;
  key_t          key_r;
  status_t       res_status_r, res_status_nxt;
  slot_idx_t     res_slot_r, res_slot_nxt;
  logic          out_valid_r;
  status_t       out_status_r;
  slot_idx_t     out_slot_r;

  logic          q_cmd;
  key_t          q_key;
  logic [AW-1:0] q_home;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  key_t          wr_data;
  logic          hit_empty, hit_key, lap_end, out_free;

  assign {q_cmd, q_key, q_home} = q_data;

  assign clearing  = (state_r == B_CLEAR);
  assign q_pop     = (state_r == B_IDLE) && q_valid;
  assign s_inc     = (s_r == LAST_SLOT) ? '0 : s_r + 1'b1;
  assign hit_empty = (rdata_r == '0);
  assign hit_key   = (rdata_r == key_r);
  assign lap_end   = (cnt_r == LAST_SLOT);
  assign out_free  = !out_valid_r || out_chan.ready;

  assign rd_addr = (state_r == B_IDLE) ? q_home : s_inc;
  assign wr_en   = clearing ||
                   ((state_r == B_PROBE) && (cmd_r == CMD_INSERT) && hit_empty);
  assign wr_addr = clearing ? clr_addr_r : s_r;
  assign wr_data = clearing ? '0 : key_r;

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.slot_index = out_slot_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_keys_r[wr_addr] <= wr_data;
    end
    rdata_r <= slot_keys_r[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    s_nxt          = s_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    unique case (state_r)
      B_CLEAR: begin
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid) begin
          s_nxt          = q_home;
          cnt_nxt        = '0;
          res_slot_nxt   = '0;
          res_status_nxt = (q_cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
          state_nxt      = (q_key == '0) ? B_DONE : B_PROBE;
        end
      end
      B_PROBE: begin
        if (cmd_r == CMD_INSERT) begin
          priority if (hit_empty) begin
            res_status_nxt = ST_INSERTED;
            res_slot_nxt   = SLOT_W'(s_r);
            state_nxt      = B_DONE;
          end else if (lap_end) begin
            state_nxt = B_DONE;
          end else begin
            s_nxt   = s_inc;
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          priority if (hit_key) begin
            res_status_nxt = ST_FOUND;
            res_slot_nxt   = SLOT_W'(s_r);
            state_nxt      = B_DONE;
          end else if (hit_empty || lap_end) begin
            state_nxt = B_DONE;
          end else begin
            s_nxt   = s_inc;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if ((state_r == B_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r          <= s_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    if (q_pop) begin
      cmd_r <= q_cmd;
      key_r <= q_key;
    end
    if ((state_r == B_DONE) && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
    end
  end

endmodule

### src/hash_table_linear_probing_core.sv
// Top level of the linear-probing hash table.
// The in_chan channel carries one transaction per operation: command selects insert
// or search, key is the positive key (zero means empty and is never stored).
// The out_chan channel returns exactly one transaction per operation, in order:
// status (inserted, table full, found, not found) and the slot index involved.
// The front end computes the home slot as (key mod HASH_MODULUS) mod TABLE_SIZE
// by reciprocal multiplication and takes a new key only after it has pushed the last one.
// A two-entry queue lets it hash the next key while the back end probes.
// The back end reads one slot per cycle from the slot store and probes up to
// TABLE_SIZE slots per operation; a zero key needs no probe.
// Sustained throughput is set by the slower of the front end and the probe loop.
// After reset the back end clears every slot of the slot store, one slot per
// cycle; in_chan.ready stays low until that pass ends.
// A result waits in the output register while out_chan.ready is low; the queue
// and the front end keep accepting work until they fill.
module hash_table_linear_probing_core #(
  parameter int TABLE_SIZE   = 16,
  parameter int HASH_MODULUS = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  htlp_in_if.sink    in_chan,
  htlp_out_if.source out_chan
);
  import htlp_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int QW = 1 + KEY_W + AW;

  logic          clearing;
  logic          q_full, q_push, q_pop, q_valid;
  logic [QW-1:0] q_wdata, q_rdata;

  htlp_front #(
    .TABLE_SIZE   (TABLE_SIZE),
    .HASH_MODULUS (HASH_MODULUS),
    .AW           (AW),
    .QW           (QW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  htlp_queue #(
    .QW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .not_empty (q_valid)
  );

  htlp_back #(
    .TABLE_SIZE (TABLE_SIZE),
    .AW         (AW),
    .QW         (QW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_chan (out_chan)
  );

endmodule

### src/htlp_checker.sv
// Port-level assertions for the hash table core and the bind that attaches them.
module htlp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input htlp_pkg::status_t   out_status,
  input htlp_pkg::slot_idx_t out_slot_index
);
  import htlp_pkg::*;

  logic [3:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 4'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 4'd1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("Channels not quiet after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result dropped while stalled.");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("Result shown without an outstanding command.");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_NOT_FOUND)
      |-> out_slot_index == '0)
    else $error("Nonzero slot index on a miss.");

endmodule

bind hash_table_linear_probing_core htlp_checker u_htlp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_status     (out_chan.status),
  .out_slot_index (out_chan.slot_index)
);
